/* design/cil_pkg.sv */
// ----------------------------------------------------------------------------
// cil_pkg
// Types, codes and constants shared by the lattice update core modules.
// ----------------------------------------------------------------------------
package cil_pkg;

  localparam int DEF_GRID_WIDTH  = 64;
  localparam int DEF_GRID_HEIGHT = 64;
  localparam int COUNT_W         = 13;
  localparam int TABLE_DEPTH     = 12;
  localparam int NEIGH_MAX       = 12;

  localparam logic [1:0] CODE_EMPTY  = 2'd0;
  localparam logic [1:0] CODE_UP     = 2'd1;
  localparam logic [1:0] CODE_DOWN   = 2'd2;
  localparam logic [1:0] CODE_UNDIFF = 2'd3;

  localparam logic [1:0] KIND_ATTEMPT = 2'd0;
  localparam logic [1:0] KIND_CELL    = 2'd1;
  localparam logic [1:0] KIND_TABLE   = 2'd2;
  localparam logic [1:0] KIND_UNKNOWN = 2'd3;

  localparam logic [1:0] REG_BIRTH = 2'd0;
  localparam logic [1:0] REG_DEATH = 2'd1;
  localparam logic [1:0] REG_DIFF  = 2'd2;
  localparam logic [1:0] REG_WIDE  = 2'd3;

  typedef struct packed {
    logic [1:0]  kind;
    logic [5:0]  site_x;
    logic [5:0]  site_y;
    logic [1:0]  neighbour_pick;
    logic [31:0] rand_first;
    logic [31:0] rand_second;
    logic        spin_pick;
    logic [1:0]  cell_code;
    logic [3:0]  table_index;
    logic [31:0] table_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         old_code;
    logic [1:0]         new_code;
    logic               cell_changed;
    logic [COUNT_W-1:0] occupied_total;
    logic [COUNT_W-1:0] up_total;
    logic [COUNT_W-1:0] down_total;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic       load;      // capture the input transaction
    logic       rd_focal;  // issue focal read
    logic       rd_neigh;  // issue neighbour read at index
    logic [3:0] neigh_idx;
    logic       acc_neigh; // accumulate neighbour read data
    logic       cap_focal; // capture focal read data
    logic       decide;    // compute new value and write back
    logic       publish;   // never set; the output register loads on decide
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] kind;
    logic [1:0] focal;
    logic       wide;
    logic [1:0] pick;      // birth source of the captured transaction
    logic       clearing;  // lattice sweep after reset in progress
  } sts_t;

  // neighbour offsets, dx and dy for each index
  function automatic int off_dx(input logic [3:0] i);
    case (i)
      4'd2, 4'd6: off_dx = (i == 4'd6) ? -2 : -1;
      4'd3:  off_dx = 1;
      4'd7:  off_dx = 2;
      4'd8, 4'd10: off_dx = -1;
      4'd9, 4'd11: off_dx = 1;
      default: off_dx = 0;
    endcase
  endfunction

  function automatic int off_dy(input logic [3:0] i);
    case (i)
      4'd0, 4'd8, 4'd11: off_dy = 1;
      4'd1, 4'd9, 4'd10: off_dy = -1;
      4'd4:  off_dy = 2;
      4'd5:  off_dy = -2;
      default: off_dy = 0;
    endcase
  endfunction

endpackage

/* design/cil_datapath.sv */
// ----------------------------------------------------------------------------
// cil_datapath
// Lattice memory, acceptance table, counters, neighbour balance and decision.
// ----------------------------------------------------------------------------
module cil_datapath #(
  parameter int GRID_WIDTH  = 64,
  parameter int GRID_HEIGHT = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  cil_pkg::in_item_t in_item,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [31:0]       cfg_data,
  input  cil_pkg::cmd_t     cmd,
  output cil_pkg::sts_t     sts,
  output cil_pkg::out_item_t out_item
);
  import cil_pkg::*;

  localparam int XW    = $clog2(GRID_WIDTH);
  localparam int YW    = $clog2(GRID_HEIGHT);
  localparam int DEPTH = GRID_WIDTH * GRID_HEIGHT;
  localparam int AW    = $clog2(DEPTH);

  // configuration registers
  logic [31:0] birth_threshold, death_threshold, differentiation_threshold;
  logic        wide_neighbourhood;
  always_ff @(posedge clk) begin
    if (rst) begin
      birth_threshold           <= 32'd42949673;
      death_threshold           <= 32'd4294967;
      differentiation_threshold <= 32'd429496730;
      wide_neighbourhood        <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BIRTH: birth_threshold           <= cfg_data;
        REG_DEATH: death_threshold           <= cfg_data;
        REG_DIFF:  differentiation_threshold <= cfg_data;
        REG_WIDE:  wide_neighbourhood        <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // site reduced into the grid by repeated compare and subtract
  function automatic int wrap_site(input logic [5:0] v, input int n);
    int t;
    t = int'(v);
    for (int i = 0; i < 8; i++) begin
      if (t >= n) t = t - n;
    end
    wrap_site = t;
  endfunction

  // captured transaction
  in_item_t  item;
  logic [XW-1:0] fx;
  logic [YW-1:0] fy;
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item <= in_item;
      fx   <= XW'(wrap_site(in_item.site_x, GRID_WIDTH));
      fy   <= YW'(wrap_site(in_item.site_y, GRID_HEIGHT));
    end
  end

  // wrapped neighbour address
  function automatic logic [AW-1:0] addr_of(input logic [XW-1:0] x,
                                           input logic [YW-1:0] y,
                                           input int dx, input int dy);
    int nx, ny;
    nx = int'(x) + dx;
    ny = int'(y) + dy;
    if (nx < 0) nx = nx + GRID_WIDTH;
    else if (nx >= GRID_WIDTH) nx = nx - GRID_WIDTH;
    if (ny < 0) ny = ny + GRID_HEIGHT;
    else if (ny >= GRID_HEIGHT) ny = ny - GRID_HEIGHT;
    addr_of = AW'(ny * GRID_WIDTH + nx);
  endfunction

  logic [AW-1:0] focal_addr;
  assign focal_addr = AW'(int'(fy) * GRID_WIDTH + int'(fx));

  // lattice memory, swept empty after reset
  logic [1:0]    lattice [DEPTH];
  logic [1:0]    rd_data;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [1:0]    new_val;
  logic [AW:0]   clr_cnt;
  logic          clearing;

  assign clearing = !clr_cnt[AW];

  always_comb begin
    if (cmd.rd_focal) rd_addr = focal_addr;
    else rd_addr = addr_of(fx, fy, off_dx(cmd.neigh_idx), off_dy(cmd.neigh_idx));
  end

  always_ff @(posedge clk) begin
    if (rst) clr_cnt <= '0;
    else if (clearing) clr_cnt <= clr_cnt + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (clearing) lattice[clr_cnt[AW-1:0]] <= CODE_EMPTY;
    else if (wr_en) lattice[focal_addr] <= new_val;
    rd_data <= lattice[rd_addr];
  end

  // acceptance table
  logic [31:0] acc_table [TABLE_DEPTH];
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TABLE_DEPTH; i++) acc_table[i] <= '0;
    end else if (cmd.decide && item.kind == KIND_TABLE &&
                 item.table_index < 4'(TABLE_DEPTH)) begin
      acc_table[item.table_index] <= item.table_value;
    end
  end

  // focal capture and neighbour balance
  logic [1:0]        focal;
  logic signed [4:0] bal;
  logic [1:0]        src;
  always_ff @(posedge clk) begin
    if (cmd.load) bal <= '0;
    if (cmd.cap_focal) focal <= rd_data;
    if (cmd.acc_neigh) begin
      src <= rd_data;
      if (rd_data == CODE_UP) bal <= bal + 5'sd1;
      else if (rd_data == CODE_DOWN) bal <= bal - 5'sd1;
    end
  end

  // decision
  logic signed [4:0] k;
  logic [31:0]       acc_val;
  logic [3:0]        kidx;
  assign k    = (focal == CODE_UP) ? bal : -bal;
  assign kidx = 4'(k - 5'sd1);
  assign acc_val = (kidx < 4'(TABLE_DEPTH)) ? acc_table[kidx] : 32'd0;

  always_comb begin
    new_val = focal;
    case (item.kind)
      KIND_ATTEMPT: begin
        if (focal == CODE_EMPTY) begin
          if (item.rand_first < birth_threshold) new_val = src;
        end else if (focal == CODE_UNDIFF) begin
          if (item.rand_first < death_threshold) new_val = CODE_EMPTY;
          else if (item.rand_second < differentiation_threshold)
            new_val = item.spin_pick ? CODE_UP : CODE_DOWN;
        end else begin
          if (item.rand_first < death_threshold) new_val = CODE_EMPTY;
          else if (k <= 5'sd0 || item.rand_second < acc_val)
            new_val = (focal == CODE_UP) ? CODE_DOWN : CODE_UP;
        end
      end
      KIND_CELL: new_val = item.cell_code;
      default:   new_val = focal;
    endcase
  end

  assign wr_en = cmd.decide && (new_val != focal);

  // running counts
  logic [COUNT_W-1:0] occ, up, dn;
  logic [COUNT_W-1:0] occ_next, up_next, dn_next;
  always_comb begin
    occ_next = occ;
    up_next  = up;
    dn_next  = dn;
    if (new_val != focal) begin
      occ_next = occ_next - COUNT_W'(focal != CODE_EMPTY)
                          + COUNT_W'(new_val != CODE_EMPTY);
      up_next  = up_next - COUNT_W'(focal == CODE_UP) + COUNT_W'(new_val == CODE_UP);
      dn_next  = dn_next - COUNT_W'(focal == CODE_DOWN)
                         + COUNT_W'(new_val == CODE_DOWN);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= '0;
      up  <= '0;
      dn  <= '0;
    end else if (cmd.decide) begin
      occ <= occ_next;
      up  <= up_next;
      dn  <= dn_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      out_item.old_code       <= focal;
      out_item.new_code       <= new_val;
      out_item.cell_changed   <= (new_val != focal);
      out_item.occupied_total <= occ_next;
      out_item.up_total       <= up_next;
      out_item.down_total     <= dn_next;
    end
  end

  assign sts.kind     = item.kind;
  assign sts.focal    = focal;
  assign sts.wide     = wide_neighbourhood;
  assign sts.pick     = item.neighbour_pick;
  assign sts.clearing = clearing;

endmodule

/* design/cil_ctrl.sv */
// ----------------------------------------------------------------------------
// cil_ctrl
// Sequencer for focal read, neighbour reads, decision and output handshake.
// ----------------------------------------------------------------------------
module cil_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          busy_clear,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  input  cil_pkg::sts_t sts,
  output cil_pkg::cmd_t cmd
);
  import cil_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_FOCAL = 6'b000010,
    S_FWAIT = 6'b000100,
    S_NEIGH = 6'b001000,
    S_DEC   = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  state_t     state, state_next;
  logic [3:0] idx, idx_next;
  logic       rd_pend, rd_pend_next;
  logic       out_full;
  logic [3:0] last_idx;
  logic [3:0] pick_idx;

  always_comb begin
    case (sts.pick)
      2'd0:    pick_idx = 4'd1;
      2'd1:    pick_idx = 4'd0;
      2'd2:    pick_idx = 4'd2;
      default: pick_idx = 4'd3;
    endcase
  end

  assign last_idx = sts.wide ? 4'd11 : 4'd3;
  assign in_stall = (state != S_IDLE) || busy_clear || (out_full && out_stall);
  assign out_valid = out_full;

  // output register occupancy
  always_ff @(posedge clk) begin
    if (rst) out_full <= 1'b0;
    else if (cmd.decide) out_full <= 1'b1;
    else if (!out_stall) out_full <= 1'b0;
  end

  // sequencer
  always_comb begin
    state_next   = state;
    idx_next     = idx;
    rd_pend_next = 1'b0;
    cmd          = '0;
    unique case (state)
      S_IDLE: if (in_valid && !in_stall) begin
        cmd.load   = 1'b1;
        state_next = S_FOCAL;
      end
      S_FOCAL: begin
        cmd.rd_focal = 1'b1;
        state_next   = S_FWAIT;
      end
      S_FWAIT: begin
        cmd.cap_focal = 1'b1;
        idx_next      = 4'd0;
        state_next    = S_NEIGH;
      end
      S_NEIGH: begin
        cmd.acc_neigh = rd_pend;
        if (sts.kind != KIND_ATTEMPT || sts.focal == CODE_UNDIFF) begin
          state_next = S_DEC;
        end else if (sts.focal == CODE_EMPTY) begin
          if (rd_pend) state_next = S_DEC;
          else begin
            cmd.rd_neigh  = 1'b1;
            cmd.neigh_idx = pick_idx;
            rd_pend_next  = 1'b1;
          end
        end else if (rd_pend && idx == last_idx + 4'd1) begin
          state_next = S_DEC;
        end else begin
          cmd.rd_neigh  = 1'b1;
          cmd.neigh_idx = idx;
          rd_pend_next  = 1'b1;
          idx_next      = idx + 4'd1;
        end
      end
      S_DEC: if (!out_full || !out_stall) begin
        cmd.decide = 1'b1;
        state_next = S_IDLE;
      end
      S_OUT: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      idx     <= '0;
      rd_pend <= 1'b0;
    end else begin
      state   <= state_next;
      idx     <= idx_next;
      rd_pend <= rd_pend_next;
    end
  end

  // checks
  a_dec_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.decide |=> state == S_IDLE) else $error("decide not followed by idle");
  a_load_focal: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> cmd.rd_focal) else $error("focal read missing after load");
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    out_full && out_stall |=> out_full) else $error("result dropped");

endmodule

/* design/contact_ising_lattice_update_core.sv */
// ----------------------------------------------------------------------------
// contact_ising_lattice_update_core
// Lattice update with birth, death, differentiation and Metropolis flips.
// ----------------------------------------------------------------------------
// steps: focal read, neighbour reads (none for writes and undifferentiated
// sites, one for empty sites, four or twelve for spin sites) on one lattice
// memory read port, one read per cycle, then the decision into the output
// register, held while that register is full and stalled. No new transaction
// is taken until the current one is decided. reset: counts, table and
// registers clear at once; the lattice is swept empty while input stays stalled.
module contact_ising_lattice_update_core #(
  parameter int GRID_WIDTH  = cil_pkg::DEF_GRID_WIDTH,
  parameter int GRID_HEIGHT = cil_pkg::DEF_GRID_HEIGHT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  cil_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output cil_pkg::out_item_t  out_data,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_data
);
  import cil_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic busy_clear;

  // input held off while the lattice sweep runs
  assign busy_clear = sts.clearing;

  cil_datapath #(.GRID_WIDTH(GRID_WIDTH), .GRID_HEIGHT(GRID_HEIGHT)) u_dp (
    .clk, .rst, .in_item(in_data), .cfg_we, .cfg_index, .cfg_data,
    .cmd, .sts, .out_item(out_data)
  );

  cil_ctrl u_ctrl (
    .clk, .rst, .busy_clear, .in_valid, .in_stall, .out_valid, .out_stall,
    .sts, .cmd
  );

endmodule

/* dv/contact_ising_lattice_update_checker.sv */
// ----------------------------------------------------------------------------
// contact_ising_lattice_update_checker
// Watches the input and result channels and the register port of the
// lattice update core, tracks the lattice, table and counts in its own
// model, and compares every result transaction with the predicted one.
// ----------------------------------------------------------------------------
module contact_ising_lattice_update_checker
  import cil_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  in_item_t    in_data,
  input  logic        out_valid,
  input  logic        out_stall,
  input  out_item_t   out_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          fail_count,
  output int          pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int GW = DEF_GRID_WIDTH;
  localparam int GH = DEF_GRID_HEIGHT;

  // model state
  logic [1:0]         grid [GW*GH];
  logic [31:0]        accept_prob [TABLE_DEPTH];
  logic [COUNT_W-1:0] occ_n, up_n, down_n;
  logic [31:0]        birth_th, death_th, diff_th;
  logic               wide_nb;
  out_item_t          expected_q [$];

  assign pending_count = expected_q.size();

  function automatic logic [1:0] cell_rel(int x, int y, int dx, int dy);
    int nx, ny;
    nx = (x + GW + dx) % GW;
    ny = (y + GH + dy) % GH;
    return grid[ny*GW + nx];
  endfunction

  function automatic void tally(logic [1:0] c, logic [COUNT_W-1:0] d);
    if (c != CODE_EMPTY) occ_n = occ_n + d;
    if (c == CODE_UP) up_n = up_n + d;
    if (c == CODE_DOWN) down_n = down_n + d;
  endfunction

  // spin balance over four or twelve neighbours
  function automatic int spin_balance(int x, int y);
    int ox [12] = '{0, 0, -1, 1, 0, 0, -2, 2, -1, 1, -1, 1};
    int oy [12] = '{1, -1, 0, 0, 2, -2, 0, 0, 1, -1, -1, 1};
    int bal, n;
    logic [1:0] c;
    bal = 0;
    n = wide_nb ? 12 : 4;
    for (int i = 0; i < n; i++) begin
      c = cell_rel(x, y, ox[i], oy[i]);
      if (c == CODE_UP) bal++;
      else if (c == CODE_DOWN) bal--;
    end
    return bal;
  endfunction

  function automatic out_item_t lattice_step(in_item_t it);
    int x, y, k, addr;
    logic [1:0] prev, nxt;
    out_item_t r;
    x = int'(it.site_x) % GW;
    y = int'(it.site_y) % GH;
    addr = y*GW + x;
    prev = grid[addr];
    nxt = prev;
    if (it.kind == KIND_ATTEMPT) begin
      if (prev == CODE_EMPTY) begin
        case (it.neighbour_pick)
          2'd0: nxt = cell_rel(x, y, 0, -1);
          2'd1: nxt = cell_rel(x, y, 0, 1);
          2'd2: nxt = cell_rel(x, y, -1, 0);
          default: nxt = cell_rel(x, y, 1, 0);
        endcase
        if (!(it.rand_first < birth_th)) nxt = prev;
      end else if (prev == CODE_UNDIFF) begin
        if (it.rand_first < death_th) nxt = CODE_EMPTY;
        else if (it.rand_second < diff_th) nxt = it.spin_pick ? CODE_UP : CODE_DOWN;
      end else begin
        k = spin_balance(x, y);
        if (prev == CODE_DOWN) k = -k;
        if (it.rand_first < death_th) nxt = CODE_EMPTY;
        else if (k <= 0 || it.rand_second < accept_prob[k-1])
          nxt = (prev == CODE_UP) ? CODE_DOWN : CODE_UP;
      end
    end else if (it.kind == KIND_CELL) begin
      nxt = it.cell_code;
    end else if (it.kind == KIND_TABLE) begin
      if (it.table_index < TABLE_DEPTH) accept_prob[it.table_index] = it.table_value;
    end
    if (nxt != prev) begin
      tally(prev, '1);
      tally(nxt, 13'd1);
      grid[addr] = nxt;
    end
    r.old_code = prev;
    r.new_code = nxt;
    r.cell_changed = (nxt != prev);
    r.occupied_total = occ_n;
    r.up_total = up_n;
    r.down_total = down_n;
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  // channel monitor
  always @(posedge clk) begin
    out_item_t e;
    if (rst) begin
      foreach (grid[i]) grid[i] = CODE_EMPTY;
      foreach (accept_prob[i]) accept_prob[i] = '0;
      occ_n = '0;
      up_n = '0;
      down_n = '0;
      birth_th = 32'd42949673;
      death_th = 32'd4294967;
      diff_th = 32'd429496730;
      wide_nb = 1'b0;
      expected_q.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_BIRTH: birth_th = cfg_data;
          REG_DEATH: death_th = cfg_data;
          REG_DIFF:  diff_th = cfg_data;
          REG_WIDE:  wide_nb = cfg_data[0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) expected_q.push_back(lattice_step(in_data));
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected transaction", 1, 0);
        end else begin
          e = expected_q.pop_front();
          if (out_data.old_code != e.old_code)
            report_mismatch("old_code", int'(out_data.old_code), int'(e.old_code));
          if (out_data.new_code != e.new_code)
            report_mismatch("new_code", int'(out_data.new_code), int'(e.new_code));
          if (out_data.cell_changed != e.cell_changed)
            report_mismatch("cell_changed", int'(out_data.cell_changed),
                            int'(e.cell_changed));
          if (out_data.occupied_total != e.occupied_total)
            report_mismatch("occupied_total", int'(out_data.occupied_total),
                            int'(e.occupied_total));
          if (out_data.up_total != e.up_total)
            report_mismatch("up_total", int'(out_data.up_total), int'(e.up_total));
          if (out_data.down_total != e.down_total)
            report_mismatch("down_total", int'(out_data.down_total),
                            int'(e.down_total));
        end
      end
    end
  end

endmodule

/* dv/contact_ising_lattice_update_core_tb.sv */
// ----------------------------------------------------------------------------
// contact_ising_lattice_update_core_tb
// Drives directed and random cell writes, table writes and update attempts
// into the lattice update core across several register settings, with
// random idle bursts on both channels; the checker judges every result.
// ----------------------------------------------------------------------------
module contact_ising_lattice_update_core_tb;
  import cil_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 20000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = REG_BIRTH;
  logic [31:0] cfg_data = '0;
  int          fail_count;
  int          pending_count;
  logic        calm = 1'b0;
  int          idle_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  contact_ising_lattice_update_core u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  contact_ising_lattice_update_checker u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  // result side stall bursts
  always @(posedge clk) begin
    if (rst || calm) begin
      out_stall <= 1'b0;
    end else if ($urandom_range(0, 19) == 0) begin
      out_stall <= 1'b1;
      repeat ($urandom_range(1, 18)) @(posedge clk);
      out_stall <= 1'b0;
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // valid stays up after the transaction until the next item or an idle
  task automatic send_item(in_item_t it);
    if (!calm && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_data <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic wait_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
  endtask

  task automatic drain_results();
    wait_results();
    repeat (30) @(posedge clk);
  endtask

  // write enable stays up until the caller drops it
  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  function automatic in_item_t random_fields();
    in_item_t it;
    it = '0;
    it.site_x = 6'($urandom);
    it.site_y = 6'($urandom);
    it.neighbour_pick = 2'($urandom);
    it.rand_first = $urandom;
    it.rand_second = $urandom;
    it.spin_pick = 1'($urandom);
    it.cell_code = 2'($urandom);
    it.table_index = 4'($urandom);
    it.table_value = $urandom;
    return it;
  endfunction

  // item aimed at a small patch so neighbours interact
  function automatic in_item_t random_item();
    in_item_t it;
    int r;
    it = random_fields();
    r = $urandom_range(0, 99);
    if (r < 5) begin
      it.kind = KIND_UNKNOWN;
    end else if (r < 12) begin
      it.kind = KIND_TABLE;
      if ($urandom_range(0, 3) != 0) it.table_index = 4'($urandom_range(0, 11));
    end else if (r < 35) begin
      it.kind = KIND_CELL;
    end else begin
      it.kind = KIND_ATTEMPT;
    end
    if ($urandom_range(0, 4) != 0) begin
      it.site_x = 6'(6'd62 + $urandom_range(0, 5));
      it.site_y = 6'(6'd62 + $urandom_range(0, 5));
    end
    if ($urandom_range(0, 3) == 0) it.rand_first = $urandom_range(0, 255);
    if ($urandom_range(0, 3) == 0) it.rand_second = $urandom_range(0, 255);
    if ($urandom_range(0, 5) == 0) it.rand_first = 32'hFFFF_FFFF - $urandom_range(0, 3);
    return it;
  endfunction

  initial begin
    in_item_t it;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed: cells at the torus corners, every code, table extremes
    for (int c = 0; c < 4; c++) begin
      it = random_fields();
      it.kind = KIND_CELL;
      it.site_x = (c[0]) ? 6'd63 : 6'd0;
      it.site_y = (c[1]) ? 6'd63 : 6'd0;
      it.cell_code = c[1:0];
      send_item(it);
    end
    it = random_fields(); it.kind = KIND_TABLE; it.table_index = 4'd0;
    it.table_value = 32'hFFFF_FFFF; send_item(it);
    it = random_fields(); it.kind = KIND_TABLE; it.table_index = 4'd11;
    it.table_value = 32'd0; send_item(it);
    it = random_fields(); it.kind = KIND_TABLE; it.table_index = 4'd15; send_item(it);
    it = random_fields(); it.kind = KIND_UNKNOWN; it.site_x = 6'd63; it.site_y = 6'd63;
    send_item(it);
    // birth from each neighbour direction, empty source included
    for (int p = 0; p < 4; p++) begin
      it = random_fields(); it.kind = KIND_ATTEMPT;
      it.site_x = 6'd0; it.site_y = 6'd63; it.neighbour_pick = 2'(p);
      it.rand_first = 32'd0; send_item(it);
    end
    // undifferentiated: death, then differentiation, then spin attempts
    for (int s = 0; s < 3; s++) begin
      it = random_fields(); it.kind = KIND_ATTEMPT;
      it.site_x = 6'd63; it.site_y = 6'd0;
      it.rand_first = (s == 0) ? 32'd0 : 32'hFFFF_FFFF;
      it.rand_second = 32'd0; send_item(it);
      it = random_fields(); it.kind = KIND_CELL; it.site_x = 6'd63; it.site_y = 6'd0;
      it.cell_code = CODE_UNDIFF; send_item(it);
    end
    for (int s = 0; s < 4; s++) begin
      it = random_fields(); it.kind = KIND_ATTEMPT; it.site_x = 6'd63; it.site_y = 6'd63;
      it.rand_first = 32'hFFFF_FFFF; it.rand_second = 32'd0; send_item(it);
    end
    // all-ones fields once
    it = '1; it.kind = KIND_ATTEMPT; send_item(it);
    drain_results();

    // random phases over register settings, extremes included
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin write_reg(REG_BIRTH, '1); write_reg(REG_DEATH, '0);
                 write_reg(REG_DIFF, '1); write_reg(REG_WIDE, 32'd0); end
        1: begin write_reg(REG_BIRTH, '1); write_reg(REG_DEATH, 32'h2000_0000);
                 write_reg(REG_DIFF, 32'h8000_0000); write_reg(REG_WIDE, 32'd1); end
        2: begin write_reg(REG_BIRTH, '0); write_reg(REG_DEATH, '1);
                 write_reg(REG_DIFF, '0); write_reg(REG_WIDE, 32'hFFFF_FFFE); end
        3: begin write_reg(REG_BIRTH, $urandom); write_reg(REG_DEATH, $urandom);
                 write_reg(REG_DIFF, $urandom); write_reg(REG_WIDE, 32'hFFFF_FFFF); end
        4: begin write_reg(REG_BIRTH, 32'hC000_0000); write_reg(REG_DEATH, 32'h0100_0000);
                 write_reg(REG_DIFF, 32'hC000_0000); write_reg(REG_WIDE, 32'd1); end
        default: begin write_reg(REG_BIRTH, 32'h8000_0000); write_reg(REG_DEATH, 32'd1);
                 write_reg(REG_DIFF, $urandom); write_reg(REG_WIDE, 32'd0); end
      endcase
      cfg_we <= 1'b0;
      if (ph == 5) calm <= 1'b1;
      for (int n = 0; n < 215; n++) begin
        send_item(random_item());
        if (n == 100 && ph == 1) wait_results();
      end
      drain_results();
    end

    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
